// ===== hw/rtl/lcsr_pkg.sv =====
// shared types and constants of the character set removal filter
`default_nettype none

package lcsr_pkg;

	// default text store depth
	localparam int unsigned TEXT_DEPTH_DEF = 64;

	// size of the remove set, one entry for each byte value
	localparam int unsigned SET_SIZE = 256;

	// characters with a meaning in the stream
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// where the current line stands
	typedef enum logic [1:0] {
		PH_TEXT,
		PH_COMMA,
		PH_SET,
		PH_WAIT
	} phase_t;

	// flush sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOOK,
		ST_CHECK,
		ST_FINAL
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcsr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module lcsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/line_char_set_remover.sv =====
// top level of the character set removal filter
//
//  channel | valid     | stall     | words
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | in_byte, end_of_input
//  out     | out_valid | out_stall | out_byte, has_byte, last_of_line, truncated
//
// a byte that does not close a line makes at most one write into the text
// memory or one mark in the set memory.
// during a flush in_stall stays high, also through any output stall: each
// stored byte is read once from the text memory, then looked up in the set
// memory, and one more scan step and the final word close the line.
// in_stall is high for the whole flush; the last word of a line waits in the
// output register while the next input words are taken.
// asynchronous reset; the remove set is cleared at once through its valid
// flops, so there is no clearing pass.
`default_nettype none

module line_char_set_remover #(
	parameter int unsigned TEXT_DEPTH = lcsr_pkg::TEXT_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] out_byte,
	output logic            has_byte,
	output logic            last_of_line,
	output logic            truncated
);

	localparam int unsigned AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TEXT_DEPTH + 1);
	localparam int unsigned SW = $clog2(lcsr_pkg::SET_SIZE);
	localparam logic [CW-1:0] DEPTH_C = CW'(TEXT_DEPTH);

	lcsr_pkg::state_t state_q, state_d;
	lcsr_pkg::phase_t phase_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          ovf_q;
	logic          pend_valid_q;
	logic [7:0]    pend_byte_q;
	logic          carry_valid_q;
	logic [7:0]    carry_byte_q;
	logic [lcsr_pkg::SET_SIZE-1:0] set_vld_q;
	logic          vld_rd_q;
	logic          out_valid_q;

	// memory ports
	logic          txt_we, txt_re;
	logic [AW-1:0] txt_waddr;
	logic [7:0]    txt_wdata, txt_rdata;
	logic          set_we, set_re;
	logic [0:0]    set_rdata;

	// decoded input word
	logic          in_acc;
	logic          is_nl, is_comma, above_sp;
	logic          do_store, do_mark, do_flush;
	logic          scan_done, keep, slot_free, advance;
	logic          out_load, out_last, out_has;
	logic [7:0]    out_data;

	lcsr_ram #(
		.WIDTH(8),
		.DEPTH(TEXT_DEPTH)
	) u_text_ram (
		.clk    (clk),
		.wr_en  (txt_we),
		.wr_addr(txt_waddr),
		.wr_data(txt_wdata),
		.rd_en  (txt_re),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(txt_rdata)
	);

	lcsr_ram #(
		.WIDTH(1),
		.DEPTH(lcsr_pkg::SET_SIZE)
	) u_set_ram (
		.clk    (clk),
		.wr_en  (set_we),
		.wr_addr(in_byte[SW-1:0]),
		.wr_data(1'b1),
		.rd_en  (set_re),
		.rd_addr(txt_rdata[SW-1:0]),
		.rd_data(set_rdata)
	);

	// input word decode
	always_comb begin
		in_acc   = in_valid && (state_q == lcsr_pkg::ST_IDLE);
		is_nl    = (in_byte == lcsr_pkg::CHAR_NEWLINE);
		is_comma = (in_byte == lcsr_pkg::CHAR_COMMA);
		above_sp = (in_byte > lcsr_pkg::CHAR_SPACE);
		do_store = 1'b0;
		do_mark  = 1'b0;
		do_flush = 1'b0;
		if (in_acc) begin
			if (end_of_input) begin
				do_flush = 1'b1;
			end else if (!is_nl) begin
				case (phase_q)
					lcsr_pkg::PH_TEXT:  do_store = !is_comma;
					lcsr_pkg::PH_COMMA: do_mark  = above_sp;
					lcsr_pkg::PH_SET:   do_mark  = 1'b1;
					default:            do_flush = above_sp;
				endcase
			end
		end
	end

	// scan status
	always_comb begin
		scan_done = (idx_q == count_q);
		keep      = !(set_rdata[0] && vld_rd_q);
		slot_free = !out_valid_q || !out_stall;
		advance   = !keep || !pend_valid_q || slot_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcsr_pkg::ST_IDLE:  if (do_flush) state_d = lcsr_pkg::ST_SCAN;
			lcsr_pkg::ST_SCAN:  state_d = scan_done ? lcsr_pkg::ST_FINAL : lcsr_pkg::ST_LOOK;
			lcsr_pkg::ST_LOOK:  state_d = lcsr_pkg::ST_CHECK;
			lcsr_pkg::ST_CHECK: if (advance) state_d = lcsr_pkg::ST_SCAN;
			lcsr_pkg::ST_FINAL: if (slot_free) state_d = lcsr_pkg::ST_IDLE;
			default:            state_d = lcsr_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and output load
	always_comb begin
		txt_we    = 1'b0;
		txt_waddr = count_q[AW-1:0];
		txt_wdata = in_byte;
		txt_re    = 1'b0;
		set_we    = 1'b0;
		set_re    = 1'b0;
		out_load  = 1'b0;
		out_last  = 1'b0;
		out_has   = 1'b1;
		out_data  = pend_byte_q;
		unique case (state_q)
			lcsr_pkg::ST_IDLE: begin
				txt_we = do_store && (count_q < DEPTH_C);
				set_we = do_mark;
			end
			lcsr_pkg::ST_SCAN: begin
				txt_re = !scan_done;
			end
			lcsr_pkg::ST_LOOK: begin
				set_re = 1'b1;
			end
			lcsr_pkg::ST_CHECK: begin
				out_load = keep && pend_valid_q && slot_free;
			end
			lcsr_pkg::ST_FINAL: begin
				out_load  = slot_free;
				out_last  = 1'b1;
				out_has   = pend_valid_q;
				out_data  = pend_valid_q ? pend_byte_q : 8'h00;
				txt_we    = slot_free && carry_valid_q;
				txt_waddr = '0;
				txt_wdata = carry_byte_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lcsr_pkg::ST_IDLE;
			phase_q       <= lcsr_pkg::PH_TEXT;
			count_q       <= '0;
			idx_q         <= '0;
			ovf_q         <= 1'b0;
			pend_valid_q  <= 1'b0;
			carry_valid_q <= 1'b0;
			set_vld_q     <= '0;
			vld_rd_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// line phase and text count while taking input
			if (in_acc && !end_of_input) begin
				if (is_nl) begin
					phase_q <= lcsr_pkg::PH_WAIT;
				end else if (phase_q == lcsr_pkg::PH_TEXT && is_comma) begin
					phase_q <= lcsr_pkg::PH_COMMA;
				end else if (phase_q == lcsr_pkg::PH_COMMA && above_sp) begin
					phase_q <= lcsr_pkg::PH_SET;
				end
			end
			if (do_store) begin
				if (count_q < DEPTH_C) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (do_mark) begin
				set_vld_q[in_byte[SW-1:0]] <= 1'b1;
			end
			// flush start
			if (do_flush) begin
				idx_q         <= '0;
				pend_valid_q  <= 1'b0;
				carry_valid_q <= !end_of_input;
			end
			// valid bit read next to the set memory read
			if (set_re) begin
				vld_rd_q <= set_vld_q[txt_rdata[SW-1:0]];
			end
			// step to the next stored byte
			if (state_q == lcsr_pkg::ST_CHECK && advance) begin
				idx_q <= idx_q + CW'(1);
				if (keep) begin
					pend_valid_q <= 1'b1;
				end
			end
			// end of flush starts a fresh line
			if (state_q == lcsr_pkg::ST_FINAL && slot_free) begin
				phase_q   <= lcsr_pkg::PH_TEXT;
				count_q   <= carry_valid_q ? CW'(1) : '0;
				ovf_q     <= 1'b0;
				set_vld_q <= '0;
			end
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_flush) begin
			carry_byte_q <= in_byte;
		end
		if (state_q == lcsr_pkg::ST_CHECK && advance && keep) begin
			pend_byte_q <= txt_rdata;
		end
		if (out_load) begin
			out_byte     <= out_data;
			has_byte     <= out_has;
			last_of_line <= out_last;
			truncated    <= ovf_q;
		end
	end

	assign in_stall  = (state_q != lcsr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lcsr_checker.sv =====
// port level checks of the character set removal filter and their bind
`default_nettype none

module lcsr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       end_of_input,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       has_byte,
	input wire logic       last_of_line,
	input wire logic       truncated
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(has_byte) && $stable(last_of_line) && $stable(truncated))
		else $error("stalled output word changed");

	// an empty line word always closes the line
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last_of_line)
		else $error("empty line word not marked last");

	// an empty line word carries a zero byte
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'h00)
		else $error("empty line word with nonzero byte");

	// input is held off while a line is still being emitted
	a_mid_line_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_line |-> in_stall)
		else $error("input taken in the middle of a line flush");

	// truncation flag is the same across one line
	a_trunc_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_line ##1 out_valid |-> $stable(truncated))
		else $error("truncated flag changed within a line");

endmodule

bind line_char_set_remover lcsr_checker u_lcsr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.in_byte     (in_byte),
	.end_of_input(end_of_input),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.has_byte    (has_byte),
	.last_of_line(last_of_line),
	.truncated   (truncated)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the character set removal filter
`default_nettype none

module testbench;

	localparam int unsigned DEPTH = lcsr_pkg::TEXT_DEPTH_DEF;

	// one word on the output side
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_of_line;
		logic       truncated;
	} word_t;

	// one word on the input side, with an optional typed-in result
	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
		logic       typed;
		word_t      exp;
	} stim_t;

	// directed row: byte, end of input, repeat count, typed flag, typed result
	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
		logic [6:0] reps;
		logic       typed;
		word_t      exp;
	} row_t;

	localparam word_t W_NONE  = '0;
	localparam word_t W_EMPTY = {8'h00, 1'b0, 1'b1, 1'b0};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_line;
	logic       truncated;

	line_char_set_remover u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.last_of_line (last_of_line),
		.truncated    (truncated)
	);

	// directed stimulus: empty lines, full deletion, extreme bytes, lines without
	// a comma, ignored bytes in the wait phase, zero bytes, text overflow
	row_t plan [24] = '{
		{8'h00,                  1'b1, 7'd1,  1'b1, W_EMPTY},
		{8'hA5,                  1'b1, 7'd1,  1'b1, W_EMPTY},
		{8'h61,                  1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_COMMA,   1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_SPACE,   1'b0, 7'd1,  1'b0, W_NONE},
		{8'h61,                  1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_NEWLINE, 1'b0, 7'd1,  1'b0, W_NONE},
		{8'h00,                  1'b1, 7'd1,  1'b1, W_EMPTY},
		{8'h00,                  1'b0, 7'd1,  1'b0, W_NONE},
		{8'hFF,                  1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_COMMA,   1'b0, 7'd1,  1'b0, W_NONE},
		{8'hFF,                  1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_NEWLINE, 1'b0, 7'd1,  1'b0, W_NONE},
		{8'h78,                  1'b0, 7'd1,  1'b1, {8'h00, 1'b1, 1'b1, 1'b0}},
		{lcsr_pkg::CHAR_NEWLINE, 1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_SPACE,   1'b0, 7'd1,  1'b0, W_NONE},
		{lcsr_pkg::CHAR_NEWLINE, 1'b0, 7'd1,  1'b0, W_NONE},
		{8'h21,                  1'b0, 7'd1,  1'b1, {8'h78, 1'b1, 1'b1, 1'b0}},
		{lcsr_pkg::CHAR_COMMA,   1'b0, 7'd1,  1'b0, W_NONE},
		{8'h00,                  1'b0, 7'd1,  1'b0, W_NONE},
		{8'h80,                  1'b0, 7'd1,  1'b0, W_NONE},
		{8'h00,                  1'b1, 7'd1,  1'b1, {8'h21, 1'b1, 1'b1, 1'b0}},
		{8'h51,                  1'b0, 7'd66, 1'b0, W_NONE},
		{8'hFF,                  1'b1, 7'd1,  1'b0, W_NONE}
	};

	// filter state kept by the testbench
	logic [7:0]  line_text [DEPTH];
	int unsigned line_len;
	logic [255:0] del_set;
	lcsr_pkg::phase_t line_phase;
	logic        line_cut;

	word_t line_words [$];
	word_t want_words [$];
	stim_t stim_q [$];
	stim_t cur;

	int fails;
	int taken;
	int words_out;
	int lines_out;
	int cut_lines;
	bit hold_done;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	// start an empty line
	function automatic void fresh_line();
		line_len   = 0;
		del_set    = '0;
		line_phase = lcsr_pkg::PH_TEXT;
		line_cut   = 1'b0;
	endfunction

	// store a text byte or note the overflow
	function automatic void keep_text(input logic [7:0] c);
		if (line_len < DEPTH) begin
			line_text[line_len] = c;
			line_len++;
		end else begin
			line_cut = 1'b1;
		end
	endfunction

	// emit the stored text minus the marked bytes
	function automatic void flush_text();
		word_t w;
		for (int i = 0; i < line_len; i++) begin
			if (!del_set[line_text[i]]) begin
				w = {line_text[i], 1'b1, 1'b0, line_cut};
				line_words.push_back(w);
			end
		end
		if (line_words.size() == 0) begin
			w = {8'h00, 1'b0, 1'b1, line_cut};
			line_words.push_back(w);
		end else begin
			line_words[line_words.size() - 1].last_of_line = 1'b1;
		end
	endfunction

	// advance the filter by one input word
	function automatic void filter_step(input logic [7:0] c, input logic eoi);
		if (eoi) begin
			flush_text();
			fresh_line();
			return;
		end
		if (c == lcsr_pkg::CHAR_NEWLINE) begin
			line_phase = lcsr_pkg::PH_WAIT;
			return;
		end
		case (line_phase)
			lcsr_pkg::PH_TEXT: begin
				if (c == lcsr_pkg::CHAR_COMMA)
					line_phase = lcsr_pkg::PH_COMMA;
				else
					keep_text(c);
			end
			lcsr_pkg::PH_COMMA: begin
				if (c > lcsr_pkg::CHAR_SPACE) begin
					line_phase = lcsr_pkg::PH_SET;
					del_set[c] = 1'b1;
				end
			end
			lcsr_pkg::PH_SET: begin
				del_set[c] = 1'b1;
			end
			default: begin
				if (c > lcsr_pkg::CHAR_SPACE) begin
					flush_text();
					fresh_line();
					keep_text(c);
				end
			end
		endcase
	endfunction

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// text byte: small alphabet so deletions hit often, else anything but comma and newline
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 70)
			return 8'h61 + 8'($urandom_range(0, 7));
		while (b == lcsr_pkg::CHAR_COMMA || b == lcsr_pkg::CHAR_NEWLINE)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// set byte: same alphabet, else anything but newline
	function automatic logic [7:0] set_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 70)
			return 8'h61 + 8'($urandom_range(0, 7));
		while (b == lcsr_pkg::CHAR_NEWLINE)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// blank byte at or below space, never newline
	function automatic logic [7:0] blank_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 32));
		if (b == lcsr_pkg::CHAR_NEWLINE)
			b = lcsr_pkg::CHAR_SPACE;
		return b;
	endfunction

	function automatic void add_stim(input logic [7:0] b, input logic eoi);
		stim_t s;
		s = {b, eoi, 1'b0, W_NONE};
		stim_q.push_back(s);
	endfunction

	// one random line, mostly well formed
	function automatic void add_line();
		int kind;
		int len;
		int r;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// noise
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				add_stim(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			return;
		end
		len = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 70) : $urandom_range(0, 10);
		for (int i = 0; i < len; i++)
			add_stim(text_byte(), 1'b0);
		if ($urandom_range(0, 99) < 88) begin
			add_stim(lcsr_pkg::CHAR_COMMA, 1'b0);
			len = $urandom_range(0, 2);
			for (int i = 0; i < len; i++)
				add_stim(blank_byte(), 1'b0);
			len = $urandom_range(0, 5);
			for (int i = 0; i < len; i++)
				add_stim(set_byte(), 1'b0);
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			len = $urandom_range(1, 2);
			for (int i = 0; i < len; i++)
				add_stim(lcsr_pkg::CHAR_NEWLINE, 1'b0);
			len = $urandom_range(0, 2);
			for (int i = 0; i < len; i++)
				add_stim(blank_byte(), 1'b0);
		end else if (r < 92) begin
			add_stim(8'($urandom_range(0, 255)), 1'b1);
		end
	endfunction

	// accept input words into the prediction and check output words
	always @(posedge clk) begin : watch
		word_t w;
		if (arst_n && in_valid && !in_stall) begin
			line_words.delete();
			filter_step(in_byte, end_of_input);
			if (cur.typed)
				want_words.push_back(cur.exp);
			else
				foreach (line_words[i])
					want_words.push_back(line_words[i]);
			taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (want_words.size() == 0) begin
				$error("unexpected word: out_byte %h has_byte %b", out_byte, has_byte);
				fails++;
			end else begin
				w = want_words.pop_front();
				if (out_byte !== w.out_byte) begin
					$error("out_byte: expected %h, got %h", w.out_byte, out_byte);
					fails++;
				end
				if (has_byte !== w.has_byte) begin
					$error("has_byte: expected %b, got %b", w.has_byte, has_byte);
					fails++;
				end
				if (last_of_line !== w.last_of_line) begin
					$error("last_of_line: expected %b, got %b", w.last_of_line, last_of_line);
					fails++;
				end
				if (truncated !== w.truncated) begin
					$error("truncated: expected %b, got %b", w.truncated, truncated);
					fails++;
				end
				if (w.last_of_line) begin
					lines_out++;
					if (w.truncated)
						cut_lines++;
				end
			end
		end
	end

	// receiver: random stall runs, calm stretches, and one long hold-off
	initial begin : drain
		int seg_left;
		int calm;
		int len;
		bit seg_stall;
		seg_left  = 0;
		calm      = 0;
		seg_stall = 1'b0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_out >= 100) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				out_stall <= 1'b0;
				seg_stall = 1'b0;
				seg_left  = 0;
			end else begin
				if (seg_left == 0) begin
					if (calm > 0) begin
						calm--;
						seg_stall = 1'b0;
						seg_left  = 1;
					end else begin
						if ($urandom_range(0, 19) == 0)
							calm = 40;
						len = pick_gap();
						if (len > 0 && $urandom_range(0, 1)) begin
							seg_stall = 1'b1;
							seg_left  = len;
						end else begin
							seg_stall = 1'b0;
							seg_left  = $urandom_range(1, 6);
						end
					end
				end
				out_stall <= seg_stall;
				seg_left--;
			end
		end
	end

	// reset, stimulus, sender and end of run
	initial begin : main
		stim_t s;
		int gap;
		int calm;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_byte      = 8'h00;
		end_of_input = 1'b0;
		cur          = '0;
		fails        = 0;
		taken        = 0;
		words_out    = 0;
		lines_out    = 0;
		cut_lines    = 0;
		calm         = 0;
		fresh_line();

		// walk the directed table, then the random lines
		foreach (plan[i])
			for (int k = 0; k < plan[i].reps; k++) begin
				s = {plan[i].b, plan[i].eoi, plan[i].typed, plan[i].exp};
				stim_q.push_back(s);
			end
		while (stim_q.size() < 460)
			add_line();
		add_stim(8'h00, 1'b1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender
		while (stim_q.size() != 0) begin
			s = stim_q.pop_front();
			if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				if ($urandom_range(0, 19) == 0)
					calm = 30;
				gap = pick_gap();
			end
			@(negedge clk);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid     <= 1'b1;
			in_byte      <= s.b;
			end_of_input <= s.eoi;
			cur          <= s;
			do
				@(posedge clk);
			while (in_stall);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// wait for every expected word, then for the flush latency
		while (want_words.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);

		$display("covered %0d input words and %0d output words", taken, words_out);
		$display("covered %0d flushed lines, %0d of them cut at the store depth",
			lines_out, cut_lines);
		if (fails == 0 && want_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
